// ===== sv/jlgs_pkg.sv =====
// Shared types and constants for the Jacobi grid sweeper.
package jlgs_pkg;

    localparam int IDX_W   = 8;   // row address carried between top and cells
    localparam int CFG_W   = 16;
    localparam int CELL_W  = 32;

    localparam logic [1:0] CFG_GRID_SIDE   = 2'd0;
    localparam logic [1:0] CFG_SWEEP_COUNT = 2'd1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  row_index;
        logic [3:0]  col_index;
        logic signed [31:0] cell_in;
    } t_item_in;

    typedef struct packed {
        logic signed [31:0] cell_out;
        logic [1:0]  op_done;
    } t_item_out;

    typedef struct packed {
        logic             cur;      // buffer that is read
        logic [IDX_W-1:0] rd_addr;
        logic             load;     // write into both buffers
        logic [IDX_W-1:0] ld_addr;
        logic             shift;    // advance row window
        logic             st_en;    // stencil write allowed this cycle
        logic [IDX_W-1:0] st_addr;
        logic [IDX_W:0]   side;
    } t_cell_ctl;

endpackage

// ===== sv/jacobi_laplace_grid_sweeper.sv =====
// Top level: command decode, sweep sequencer and the row of column cells.
// One cell per column streams its column row by row, handing its middle row to
// both neighbors every cycle. A write, an unused opcode or a run with no sweeps
// answers straight from idle, a read after the ST_READ state, and any other run
// after sweep_count walks of rows 0 to side (grid_side capped at MAX_SIDE).
// busy is high while an item is in work; results appear for one cycle on
// o_valid and cannot be stalled, so the receiver must take them as they come.
module jacobi_laplace_grid_sweeper #(
    parameter int MAX_SIDE = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  jlgs_pkg::t_item_in    i_item,
    output logic                  o_valid,
    output jlgs_pkg::t_item_out   o_result,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data
);
    import jlgs_pkg::*;

    localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    t_state          r_state, n_state;
    logic [4:0]      r_grid_side;
    logic [15:0]     r_sweeps;
    logic [15:0]     r_left, n_left;
    logic [IDX_W:0]  r_cnt, n_cnt;
    logic            r_cur, n_cur;
    logic [CW-1:0]   r_col, n_col;
    logic            r_inside, n_inside;
    logic            r_valid, n_valid;
    t_item_out       r_result, n_result;
    logic [IDX_W:0]  side;
    logic            in_store;
    logic            accept;
    t_cell_ctl       ctl;
    logic [31:0]     mid [MAX_SIDE];
    logic [31:0]     q   [MAX_SIDE];

    assign side = (32'(r_grid_side) > 32'(MAX_SIDE)) ? (IDX_W + 1)'(MAX_SIDE)
                                                      : (IDX_W + 1)'(r_grid_side);
    assign in_store = (32'(i_item.row_index) < 32'(MAX_SIDE))
                   && (32'(i_item.col_index) < 32'(MAX_SIDE));
    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        ctl.cur     = r_cur;
        ctl.rd_addr = (r_state == ST_SWEEP) ? r_cnt[IDX_W-1:0] : IDX_W'(i_item.row_index);
        ctl.ld_addr = IDX_W'(i_item.row_index);
        ctl.load    = 1'b0;
        ctl.shift   = (r_state == ST_SWEEP);
        ctl.st_en   = (r_state == ST_SWEEP) && (r_cnt >= (IDX_W + 1)'(3));
        ctl.st_addr = r_cnt[IDX_W-1:0] - IDX_W'(2);
        ctl.side    = side;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SIDE; g++) begin : g_cell
            t_cell_ctl   c_ctl;
            logic [31:0] left_v, right_v;
            always_comb begin
                c_ctl      = ctl;
                c_ctl.load = accept && (t_op'(i_item.opcode) == OP_WRITE) && in_store
                          && (32'(i_item.col_index) == g);
            end
            if (g == 0) begin : g_l0
                assign left_v = '0;
            end else begin : g_l
                assign left_v = mid[g-1];
            end
            if (g == MAX_SIDE - 1) begin : g_r0
                assign right_v = '0;
            end else begin : g_r
                assign right_v = mid[g+1];
            end
            jlgs_cell #(.MAX_SIDE(MAX_SIDE), .COL(g)) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (c_ctl),
                .i_ld_data (i_item.cell_in),
                .i_left    (left_v),
                .i_right   (right_v),
                .o_mid     (mid[g]),
                .o_q       (q[g])
            );
        end
    endgenerate

    always_comb begin
        n_state  = r_state;
        n_left   = r_left;
        n_cnt    = r_cnt;
        n_cur    = r_cur;
        n_col    = r_col;
        n_inside = r_inside;
        n_valid  = 1'b0;
        n_result = r_result;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_result.cell_out = '0;
                    n_result.op_done  = i_item.opcode;
                    n_col    = CW'(i_item.col_index);
                    n_inside = in_store;
                    case (i_item.opcode)
                        OP_RUN: begin
                            n_cnt  = '0;
                            n_left = r_sweeps;
                            if (r_sweeps == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = ST_SWEEP;
                            end
                        end
                        OP_READ: n_state = ST_READ;
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            ST_SWEEP: begin
                if (r_cnt == side) begin
                    n_cur  = ~r_cur;
                    n_cnt  = '0;
                    n_left = r_left - 16'd1;
                    if (r_left == 16'd1) begin
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + (IDX_W + 1)'(1);
                end
            end
            ST_READ: begin
                n_result.cell_out = r_inside ? q[r_col] : '0;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= 1'b0;
            r_valid     <= 1'b0;
            r_grid_side <= 5'd16;
            r_sweeps    <= 16'd1;
            r_cnt       <= '0;
            r_left      <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            if (i_cfg_we && i_cfg_idx == CFG_GRID_SIDE) begin
                r_grid_side <= i_cfg_data[4:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_SWEEP_COUNT) begin
                r_sweeps <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col    <= n_col;
        r_inside <= n_inside;
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== sv/jlgs_cell.sv =====
// One grid column: both buffers, a three-row window and the stencil adder.
module jlgs_cell #(
    parameter int MAX_SIDE = 16,
    parameter int COL      = 0
) (
    input  logic                  i_clk,
    input  jlgs_pkg::t_cell_ctl   i_ctl,
    input  logic [31:0]           i_ld_data,
    input  logic [31:0]           i_left,
    input  logic [31:0]           i_right,
    output logic [31:0]           o_mid,
    output logic [31:0]           o_q
);
    import jlgs_pkg::*;

    localparam int RW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    logic [31:0] r_mem_a [MAX_SIDE];
    logic [31:0] r_mem_b [MAX_SIDE];
    logic [31:0] r_q;
    logic [31:0] r_up;
    logic [31:0] r_mid;
    logic [33:0] sum;
    logic        col_in;
    logic [31:0] st_val;

    assign sum = {{2{r_up[31]}}, r_up} + {{2{r_q[31]}}, r_q}
               + {{2{i_left[31]}}, i_left} + {{2{i_right[31]}}, i_right};
    assign st_val = sum[33:2];
    assign col_in = (COL >= 1) && ({1'b0, i_ctl.side} >= (IDX_W + 2)'(COL + 2));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mem_a[i_ctl.ld_addr[RW-1:0]] <= i_ld_data;
            r_mem_b[i_ctl.ld_addr[RW-1:0]] <= i_ld_data;
        end else if (i_ctl.st_en && col_in) begin
            if (i_ctl.cur) begin
                r_mem_a[i_ctl.st_addr[RW-1:0]] <= st_val;
            end else begin
                r_mem_b[i_ctl.st_addr[RW-1:0]] <= st_val;
            end
        end
        r_q <= i_ctl.cur ? r_mem_b[i_ctl.rd_addr[RW-1:0]] : r_mem_a[i_ctl.rd_addr[RW-1:0]];
        if (i_ctl.shift) begin
            r_up  <= r_mid;
            r_mid <= r_q;
        end
    end

    assign o_mid = r_mid;
    assign o_q   = r_q;

endmodule

// ===== sim/jacobi_laplace_grid_sweeper_checker.sv =====
// Checker for the Jacobi grid sweeper: predicts each result and compares it.
module jacobi_laplace_grid_sweeper_checker
    import jlgs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  logic      busy,
    input  t_item_in  i_item,
    input  logic      o_valid,
    input  t_item_out o_result,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE_MAX = 16;

    logic [31:0] plane_a [SIDE_MAX*SIDE_MAX];
    logic [31:0] plane_b [SIDE_MAX*SIDE_MAX];
    logic        plane_sel;
    logic [4:0]  side_reg;
    logic [15:0] sweeps_reg;
    t_item_out   answer_q [$];

    // Jacobi sweep on the model grid, then swap the planes.
    task automatic sweep_grid(input int side);
        logic signed [33:0] acc;
        for (int r = 1; r + 1 < side; r++) begin
            for (int c = 1; c + 1 < side; c++) begin
                if (!plane_sel) begin
                    acc = $signed(plane_a[(r-1)*SIDE_MAX+c]) + $signed(plane_a[(r+1)*SIDE_MAX+c])
                        + $signed(plane_a[r*SIDE_MAX+c-1]) + $signed(plane_a[r*SIDE_MAX+c+1]);
                    plane_b[r*SIDE_MAX+c] = 32'(acc >>> 2);
                end else begin
                    acc = $signed(plane_b[(r-1)*SIDE_MAX+c]) + $signed(plane_b[(r+1)*SIDE_MAX+c])
                        + $signed(plane_b[r*SIDE_MAX+c-1]) + $signed(plane_b[r*SIDE_MAX+c+1]);
                    plane_a[r*SIDE_MAX+c] = 32'(acc >>> 2);
                end
            end
        end
        plane_sel = ~plane_sel;
    endtask

    task automatic predict_item(input t_item_in it);
        t_item_out res;
        int side;
        int addr;
        res = '0;
        res.op_done = it.opcode;
        addr = it.row_index * SIDE_MAX + it.col_index;
        case (it.opcode)
            OP_WRITE: begin
                plane_a[addr] = it.cell_in;
                plane_b[addr] = it.cell_in;
            end
            OP_RUN: begin
                side = (side_reg > SIDE_MAX) ? SIDE_MAX : side_reg;
                for (int k = 0; k < sweeps_reg; k++) sweep_grid(side);
            end
            OP_READ: res.cell_out = plane_sel ? plane_b[addr] : plane_a[addr];
            default: ;
        endcase
        answer_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_item_out want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            plane_sel  = 1'b0;
            side_reg   = 5'd16;
            sweeps_reg = 16'd1;
            answer_q.delete();
            o_fail_count <= 0;
        end else begin
            if (o_valid) begin
                if (answer_q.size() == 0) begin
                    $error("result with nothing expected: %p", o_result);
                    errs++;
                end else begin
                    want = answer_q.pop_front();
                    if (o_result.cell_out !== want.cell_out) begin
                        $error("cell_out expected %0d got %0d", want.cell_out, o_result.cell_out);
                        errs++;
                    end
                    if (o_result.op_done !== want.op_done) begin
                        $error("op_done expected %0d got %0d", want.op_done, o_result.op_done);
                        errs++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_GRID_SIDE) side_reg = i_cfg_data[4:0];
                else if (i_cfg_idx == CFG_SWEEP_COUNT) sweeps_reg = i_cfg_data;
            end
            if (start && !busy) predict_item(i_item);
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= answer_q.size();
    end

endmodule

// ===== sim/jacobi_laplace_grid_sweeper_tb.sv =====
// Testbench top: clock, reset, stimulus and final verdict for the grid sweeper.
module jacobi_laplace_grid_sweeper_tb;
    import jlgs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000000;
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_item_in    i_item = '0;
    logic        o_valid;
    t_item_out   o_result;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_GRID_SIDE;
    logic [15:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          quiet_tail = 0;

    always #5 i_clk = ~i_clk;

    jacobi_laplace_grid_sweeper uut (.*);

    jacobi_laplace_grid_sweeper_checker chk (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_valid, .o_result,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog: count cycles with nothing accepted and no result.
    always @(posedge i_clk) begin
        if (o_valid || (start && !busy) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Hold start high until the item is taken; drop it only for an idle gap.
    task automatic issue_item(input logic [1:0] op, input int r, input int c,
                              input logic [31:0] v);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{opcode: op, row_index: 4'(r), col_index: 4'(c), cell_in: v};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain_and_write(input logic [1:0] idx, input logic [15:0] val);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy || o_valid) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_cell();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Fill the whole store so every read and stencil neighbor is defined.
    task automatic load_grid(input bit extremes);
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                issue_item(OP_WRITE, r, c, extremes ? rand_cell() : $urandom);
    endtask

    task automatic scatter_writes(input int n, input bit extremes);
        for (int k = 0; k < n; k++)
            issue_item(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                       extremes ? rand_cell() : $urandom);
    endtask

    task automatic read_some(input int n);
        int r;
        int c;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 15);
            c = $urandom_range(0, 15);
            issue_item(OP_READ, r, c, $urandom);
        end
    endtask

    initial begin
        int sides [6] = '{3, 16, 31, 2, 7, 0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme writes, reads at two corners, a run, unused opcode.
        issue_item(OP_WRITE, 0, 0, 32'h7FFF_FFFF);
        issue_item(OP_WRITE, 15, 15, 32'h8000_0000);
        issue_item(OP_READ, 0, 0, '0);
        issue_item(OP_READ, 15, 15, '0);
        issue_item(OP_SPARE, 15, 15, 32'hFFFF_FFFF);
        load_grid(1'b1);
        issue_item(OP_RUN, 9, 6, $urandom);
        read_some(8);

        // Hold off until everything has come back, then run with a sweep count of zero.
        drain_and_write(CFG_SWEEP_COUNT, 16'd0);
        issue_item(OP_RUN, 0, 0, '0);
        read_some(4);

        foreach (sides[s]) begin
            drain_and_write(CFG_GRID_SIDE, 16'(sides[s]));
            drain_and_write(CFG_SWEEP_COUNT, 16'($urandom_range(1, 3)));
            scatter_writes(16, s[0]);
            for (int k = 0; k < 3; k++) begin
                issue_item(OP_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
                read_some(10);
                if ($urandom_range(0, 3) == 0)
                    issue_item(OP_SPARE, $urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom);
            end
        end

        // A long run at the largest count on a grid of side 3.
        drain_and_write(CFG_GRID_SIDE, 16'd3);
        drain_and_write(CFG_SWEEP_COUNT, 16'hFFFF);
        issue_item(OP_RUN, 0, 0, '0);
        read_some(5);
        drain_and_write(CFG_SWEEP_COUNT, 16'd2);
        drain_and_write(CFG_GRID_SIDE, 16'd16);
        quiet_tail = 1;
        for (int k = 0; k < 60; k++) begin
            case ($urandom_range(0, 5))
                0: issue_item(OP_RUN, 0, 0, $urandom);
                1: issue_item(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                              rand_cell());
                default: read_some(1);
            endcase
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
